@@ rtl/mf2d_pkg.sv @@
package mf2d_pkg;

  localparam int unsigned FW_W = 11;
  localparam int unsigned FH_W = 13;
  localparam int unsigned KS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned PIXEL_W = 3 * SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd2;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [KS_W-1:0] KERNEL_SIZE_RST  = 3'd3;

endpackage

@@ rtl/mf2d_in_if.sv @@
interface mf2d_in_if;
  logic       valid;
  logic       ready;
  logic       flush;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output flush, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input flush, input red_in, input green_in,
                input blue_in, output ready);
endinterface

@@ rtl/mf2d_out_if.sv @@
interface mf2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_end, output ready);
endinterface

@@ rtl/median_filter_2d.sv @@
// a request with no result is taken in S_IDLE; a border pixel result goes through S_CENTER,
//   S_CWAIT and S_FIN, an interior one through S_PASS and S_DRAIN for each bit, then S_FIN
// throughput: one request per result computation; requests without result go 1 per cycle
// the single read port of the row ring sets the rate: 8 bit-search passes over the window
// reset (async, active low) clears counters, control and config registers to their defaults;
//   the row ring is not cleared, only pixels already written are ever read
module median_filter_2d
  import mf2d_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_KERNEL = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mf2d_in_if.sink               in_if,
  mf2d_out_if.source            out_if
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RR_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned DEPTH  = MAX_KERNEL * MAX_WIDTH;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned PEND_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned SH_W   = $clog2(MAX_KERNEL / 2 + 1);
  localparam int unsigned KW     = $clog2(MAX_KERNEL + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CENTER, S_CWAIT, S_PASS, S_DRAIN, S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [KS_W-1:0] kernel_size_q;

  // frame position
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [ROW_W-1:0]  in_row_q, out_row_q;
  logic [RR_W-1:0]   in_rr_q, out_rr_q;
  logic [PEND_W-1:0] pend_q;

  // window walk
  logic [RR_W-1:0]  win_rr_q, rd_rr_q, cen_rr_q;
  logic [COL_W-1:0] win_col_q, rd_col_q, cen_col_q;
  logic [KW-1:0]    it_r_q, it_c_q;
  logic             rvalid_q;
  logic [2:0]       bit_q;
  logic [7:0]       res_q [3];
  logic [CNT_W-1:0] cnt_q [3];
  logic             fend_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_red_q, out_green_q, out_blue_q;
  logic       out_fend_q;

  // effective geometry
  logic [WID_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [SH_W-1:0]   sh;
  logic [KW-1:0]     side;
  logic [CNT_W-1:0]  target;
  logic [PEND_W-1:0] lag;

  always_comb begin
    int unsigned fw, fh, kk;
    fw = 32'(frame_width_q);
    fh = 32'(frame_height_q);
    kk = 32'(kernel_size_q);
    if (fw == 0) fw = 1;
    if (fw > MAX_WIDTH) fw = MAX_WIDTH;
    if (fh == 0) fh = 1;
    if (fh > MAX_HEIGHT) fh = MAX_HEIGHT;
    if (kk > MAX_KERNEL) kk = MAX_KERNEL;
    if (kk == 0) kk = 1;
    if (kk[0] == 1'b0) kk = kk - 1;
    w_eff  = WID_W'(fw);
    h_eff  = ROW_W'(fh);
    sh     = SH_W'(kk >> 1);
    side   = KW'(kk);
    target = CNT_W'((kk * kk) >> 1);
    lag    = PEND_W'((kk >> 1) * fw + (kk >> 1));
  end

  // request decode
  logic              acc, done, is_pix, emit, border, frame_last;
  logic [PEND_W-1:0] pend_after;
  logic [COL_W-1:0]  in_col_nx, out_col_nx;
  logic [ROW_W-1:0]  in_row_nx, out_row_nx;
  logic [RR_W-1:0]   in_rr_nx, out_rr_nx, start_rr;
  logic [COL_W-1:0]  start_col;
  logic              in_wrap, out_wrap;

  assign in_if.ready = (state_q == S_IDLE);
  assign acc         = in_if.valid && in_if.ready;
  assign done        = in_row_q >= h_eff;
  assign is_pix      = !in_if.flush && !done;
  assign pend_after  = is_pix ? pend_q + PEND_W'(1) : pend_q;
  assign emit        = is_pix ? (pend_after > lag) : (done && (pend_q != '0));

  always_comb begin
    in_wrap   = 32'(in_col_q) + 1 >= 32'(w_eff);
    in_col_nx = in_wrap ? '0 : in_col_q + COL_W'(1);
    in_row_nx = in_wrap ? in_row_q + ROW_W'(1) : in_row_q;
    if (in_wrap) begin
      in_rr_nx = (32'(in_rr_q) == MAX_KERNEL - 1) ? '0 : in_rr_q + RR_W'(1);
    end else begin
      in_rr_nx = in_rr_q;
    end
    out_wrap   = 32'(out_col_q) + 1 >= 32'(w_eff);
    out_col_nx = out_wrap ? '0 : out_col_q + COL_W'(1);
    out_row_nx = out_wrap ? out_row_q + ROW_W'(1) : out_row_q;
    if (out_wrap) begin
      out_rr_nx = (32'(out_rr_q) == MAX_KERNEL - 1) ? '0 : out_rr_q + RR_W'(1);
    end else begin
      out_rr_nx = out_rr_q;
    end
    frame_last = out_row_nx >= h_eff;
    border = (32'(out_row_q) < 32'(sh)) || (32'(out_col_q) < 32'(sh)) ||
             (32'(out_row_q) + 32'(sh) >= 32'(h_eff)) ||
             (32'(out_col_q) + 32'(sh) >= 32'(w_eff));
    // window starts half a kernel up and left, ring row wraps
    if (32'(out_rr_q) >= 32'(sh)) begin
      start_rr = RR_W'(32'(out_rr_q) - 32'(sh));
    end else begin
      start_rr = RR_W'(32'(out_rr_q) + MAX_KERNEL - 32'(sh));
    end
    start_col = COL_W'(32'(out_col_q) - 32'(sh));
  end

  // row ring
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [PIXEL_W-1:0] ram_rdata;
  logic [RR_W-1:0]    rd_rr_sel;
  logic [COL_W-1:0]   rd_col_sel;

  assign ram_we    = acc && is_pix;
  assign ram_waddr = AW'(32'(in_rr_q) * MAX_WIDTH + 32'(in_col_q));
  assign ram_re    = (state_q == S_CENTER) || (state_q == S_PASS);
  assign rd_rr_sel  = (state_q == S_CENTER) ? cen_rr_q : rd_rr_q;
  assign rd_col_sel = (state_q == S_CENTER) ? cen_col_q : rd_col_q;
  assign ram_raddr = AW'(32'(rd_rr_sel) * MAX_WIDTH + 32'(rd_col_sel));

  mf2d_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_if.red_in, in_if.green_in, in_if.blue_in}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // bit search: candidate keeps decided upper bits, ones below the current bit
  logic [7:0]       sample [3];
  logic [7:0]       cand   [3];
  logic [7:0]       bit_mask;
  logic             le     [3];
  logic [CNT_W-1:0] cnt_tot [3];

  assign sample[0] = ram_rdata[23:16];
  assign sample[1] = ram_rdata[15:8];
  assign sample[2] = ram_rdata[7:0];
  assign bit_mask  = 8'd1 << bit_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      cand[ch]    = res_q[ch] | (bit_mask - 8'd1);
      le[ch]      = rvalid_q && (sample[ch] <= cand[ch]);
      cnt_tot[ch] = cnt_q[ch] + CNT_W'(le[ch]);
    end
  end

  logic last_c, last_r;
  assign last_c = (it_c_q == side - KW'(1));
  assign last_r = (it_r_q == side - KW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      kernel_size_q  <= KERNEL_SIZE_RST;
      in_col_q       <= '0;
      in_row_q       <= '0;
      in_rr_q        <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_rr_q       <= '0;
      pend_q         <= '0;
      rvalid_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      rvalid_q <= (state_q == S_PASS);
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
          CFG_KERNEL_SIZE:  kernel_size_q  <= cfg_data_i[KS_W-1:0];
          default: ;
        endcase
        if ((cfg_idx_i == CFG_FRAME_WIDTH) || (cfg_idx_i == CFG_FRAME_HEIGHT) ||
            (cfg_idx_i == CFG_KERNEL_SIZE)) begin
          // restart the frame, ring contents kept
          in_col_q  <= '0;
          in_row_q  <= '0;
          in_rr_q   <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          out_rr_q  <= '0;
          pend_q    <= '0;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (is_pix) begin
              in_col_q <= in_col_nx;
              in_row_q <= in_row_nx;
              in_rr_q  <= in_rr_nx;
            end
            pend_q <= pend_after - PEND_W'(emit);
            if (emit) begin
              cen_rr_q  <= out_rr_q;
              cen_col_q <= out_col_q;
              win_rr_q  <= start_rr;
              win_col_q <= start_col;
              rd_rr_q   <= start_rr;
              rd_col_q  <= start_col;
              it_r_q    <= '0;
              it_c_q    <= '0;
              bit_q     <= 3'd7;
              fend_q    <= frame_last;
              for (int ch = 0; ch < 3; ch++) begin
                res_q[ch] <= '0;
                cnt_q[ch] <= '0;
              end
              out_col_q <= out_col_nx;
              out_row_q <= out_row_nx;
              out_rr_q  <= out_rr_nx;
              if (frame_last) begin
                // last pixel of the frame: back to the frame start
                in_col_q  <= '0;
                in_row_q  <= '0;
                in_rr_q   <= '0;
                out_col_q <= '0;
                out_row_q <= '0;
                out_rr_q  <= '0;
                pend_q    <= '0;
              end
              state_q <= border ? S_CENTER : S_PASS;
            end
          end
        end
        S_CENTER: state_q <= S_CWAIT;
        S_CWAIT: begin
          for (int ch = 0; ch < 3; ch++) begin
            res_q[ch] <= sample[ch];
          end
          state_q <= S_FIN;
        end
        S_PASS: begin
          for (int ch = 0; ch < 3; ch++) begin
            cnt_q[ch] <= cnt_tot[ch];
          end
          if (last_c) begin
            it_c_q   <= '0;
            rd_col_q <= win_col_q;
            it_r_q   <= it_r_q + KW'(1);
            rd_rr_q  <= (32'(rd_rr_q) == MAX_KERNEL - 1) ? '0 : rd_rr_q + RR_W'(1);
            if (last_r) begin
              state_q <= S_DRAIN;
            end
          end else begin
            it_c_q   <= it_c_q + KW'(1);
            rd_col_q <= rd_col_q + COL_W'(1);
          end
        end
        S_DRAIN: begin
          for (int ch = 0; ch < 3; ch++) begin
            cnt_q[ch] <= '0;
            if (cnt_tot[ch] <= target) begin
              res_q[ch] <= res_q[ch] | bit_mask;
            end
          end
          it_r_q   <= '0;
          it_c_q   <= '0;
          rd_rr_q  <= win_rr_q;
          rd_col_q <= win_col_q;
          if (bit_q == 3'd0) begin
            state_q <= S_FIN;
          end else begin
            bit_q   <= bit_q - 3'd1;
            state_q <= S_PASS;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_red_q   <= res_q[0];
            out_green_q <= res_q[1];
            out_blue_q  <= res_q[2];
            out_fend_q  <= fend_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.red_out   = out_red_q;
  assign out_if.green_out = out_green_q;
  assign out_if.blue_out  = out_blue_q;
  assign out_if.frame_end = out_fend_q;

endmodule

@@ rtl/mf2d_ram.sv @@
module mf2d_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 7168
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/mf2d_checker.sv @@
module mf2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_red_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_blue_i,
  input logic       out_frame_end_i
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_red_i) && $stable(out_green_i) &&
      $stable(out_blue_i) && $stable(out_frame_end_i))
    else $error("result changed while stalled");

  // no result while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result during reset");

  // a new result is only loaded while the input side is busy computing
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a computation");

  // a stalled result stays valid when a request is taken
  a_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result lost on request");

endmodule

bind median_filter_2d mf2d_checker u_mf2d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_red_i       (out_if.red_out),
  .out_green_i     (out_if.green_out),
  .out_blue_i      (out_if.blue_out),
  .out_frame_end_i (out_if.frame_end)
);

@@ tb/median_filter_2d_tb.sv @@
module median_filter_2d_tb;
  import mf2d_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 4096;
  localparam int unsigned MAX_K = 7;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  // settle time before a register write; covers the slowest interior pixel (k = 7)
  localparam int unsigned SETTLE_CYCLES = 500;

  typedef struct packed {
    logic                flush;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                frame_end;
  } pixel_rsp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mf2d_in_if  pix_in ();
  mf2d_out_if pix_out ();

  median_filter_2d i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (pix_in),
    .out_if     (pix_out)
  );

  // request queue feeding the driver, and the predicted pixels still owed by the block
  pixel_req_t req_queue[$];
  pixel_rsp_t owed_pixels[$];

  int unsigned mismatches;
  int unsigned req_count;
  int unsigned rsp_count;
  int unsigned frame_count;
  int unsigned pushed;
  int unsigned phases;
  int unsigned idle_cycles;
  bit          cfg_activity;
  bit          burst_mode;

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the row ring, counters and registers
  // ---------------------------------------------------------------------------
  logic [PIXEL_W-1:0] ring_mem [MAX_K*MAX_W];
  int unsigned        in_row, in_col, out_row, out_col;
  logic [FW_W-1:0]    reg_width;
  logic [FH_W-1:0]    reg_height;
  logic [KS_W-1:0]    reg_kernel;

  function automatic int unsigned eff_width(logic [FW_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return 32'(w);
  endfunction

  function automatic int unsigned eff_height(logic [FH_W-1:0] h);
    if (h == 0) return 1;
    if (h > MAX_H) return MAX_H;
    return 32'(h);
  endfunction

  // half window: clamp, then round even sizes down to odd
  function automatic int unsigned eff_half(logic [KS_W-1:0] k);
    int unsigned kk;
    kk = 32'(k);
    if (kk > MAX_K) kk = MAX_K;
    if (kk == 0) kk = 1;
    if ((kk & 1) == 0) kk = kk - 1;
    return kk / 2;
  endfunction

  function automatic logic [PIXEL_W-1:0] ring_at(int unsigned r, int unsigned c);
    return ring_mem[(r % MAX_K) * MAX_W + (c % MAX_W)];
  endfunction

  // counting-sort median of one channel over the window centered at (r, c)
  function automatic logic [7:0] window_median(int unsigned r, int unsigned c,
                                               int unsigned sh, int unsigned shift);
    int unsigned hist [256];
    int unsigned side, target, acc, v;
    logic [PIXEL_W-1:0] px;
    for (int i = 0; i < 256; i++) hist[i] = 0;
    side = 2 * sh + 1;
    for (int unsigned i = r - sh; i <= r + sh; i++) begin
      for (int unsigned j = c - sh; j <= c + sh; j++) begin
        px = ring_at(i, j);
        hist[(px >> shift) & 8'hff]++;
      end
    end
    target = (side * side) / 2;
    acc = 0;
    for (v = 0; v < 255; v++) begin
      acc += hist[v];
      if (acc > target) break;
    end
    return v[7:0];
  endfunction

  // produce the next output pixel and advance the output position
  function automatic pixel_rsp_t next_out_pixel(int unsigned w, int unsigned h,
                                                int unsigned sh);
    pixel_rsp_t rsp;
    logic [PIXEL_W-1:0] px;
    bit border;
    border = (out_row < sh) || (out_col < sh) || (out_row + sh >= h) ||
             (out_col + sh >= w);
    px = ring_at(out_row, out_col);
    if (border) begin
      rsp.red   = px[23:16];
      rsp.green = px[15:8];
      rsp.blue  = px[7:0];
    end else begin
      rsp.red   = window_median(out_row, out_col, sh, 16);
      rsp.green = window_median(out_row, out_col, sh, 8);
      rsp.blue  = window_median(out_row, out_col, sh, 0);
    end
    rsp.frame_end = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      rsp.frame_end = 1'b1;
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    end
    return rsp;
  endfunction

  // one accepted request: store the pixel and queue whatever result it releases
  function automatic void predict_filter(pixel_req_t req);
    int unsigned w, h, sh, lag, in_cnt, out_cnt;
    bit frame_done;
    w = eff_width(reg_width);
    h = eff_height(reg_height);
    sh = eff_half(reg_kernel);
    lag = sh * w + sh;
    frame_done = in_row >= h;
    if (!req.flush && !frame_done) begin
      ring_mem[(in_row % MAX_K) * MAX_W + in_col] = {req.red, req.green, req.blue};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      in_cnt = in_row * w + in_col;
      out_cnt = out_row * w + out_col;
      if (in_cnt - out_cnt > lag) owed_pixels.push_back(next_out_pixel(w, h, sh));
    end else if (frame_done) begin
      // past the frame end, a flush or a pixel drains one pending pixel
      if (out_row * w + out_col < h * w) owed_pixels.push_back(next_out_pixel(w, h, sh));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // driver: pops requests and holds each one until it is accepted
  // ---------------------------------------------------------------------------
  pixel_req_t  cur_req;
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_in.valid    <= 1'b0;
      pix_in.flush    <= 1'b0;
      pix_in.red_in   <= '0;
      pix_in.green_in <= '0;
      pix_in.blue_in  <= '0;
      send_gap        <= 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        predict_filter(cur_req);
        req_count++;
      end
      // only move on once the current request is gone
      if (!pix_in.valid || pix_in.ready) begin
        if (send_gap > 0) begin
          send_gap     <= send_gap - 1;
          pix_in.valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          cur_req          = req_queue.pop_front();
          pix_in.valid    <= 1'b1;
          pix_in.flush    <= cur_req.flush;
          pix_in.red_in   <= cur_req.red;
          pix_in.green_in <= cur_req.green;
          pix_in.blue_in  <= cur_req.blue;
          send_gap        <= burst_mode ? 0 : $urandom_range(0, 18);
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, compares each result with the oldest prediction
  // ---------------------------------------------------------------------------
  int unsigned stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_rsp_t got, want;
    int unsigned stall_draw;
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        got.red       = pix_out.red_out;
        got.green     = pix_out.green_out;
        got.blue      = pix_out.blue_out;
        got.frame_end = pix_out.frame_end;
        rsp_count++;
        if (got.frame_end) frame_count++;
        if (owed_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result r=%0d g=%0d b=%0d end=%0b",
                     got.red, got.green, got.blue, got.frame_end);
        end else begin
          want = owed_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: exp r=%0d g=%0d b=%0d e=%0b, got r=%0d g=%0d b=%0d e=%0b",
                       rsp_count, want.red, want.green, want.blue, want.frame_end,
                       got.red, got.green, got.blue, got.frame_end);
          end
        end
        // draw the stall before the next result
        stall_draw    = burst_mode ? 0 : $urandom_range(0, 18);
        stall_left    <= stall_draw;
        pix_out.ready <= (stall_draw == 0);
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        pix_out.ready <= (stall_left == 1);
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: cycles without any accepted request, result or register write
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || cfg_activity)
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired: %0d requests, %0d results", req_count, rsp_count);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(bit f, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_req_t req;
    req.flush = f;
    req.red   = r;
    req.green = g;
    req.blue  = b;
    req_queue.push_back(req);
    pushed++;
  endtask

  task automatic push_random_pixel();
    push_req(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
  endtask

  // wait until every request is gone and every result is in, then let the
  // block finish any request that produced no result
  task automatic wait_idle();
    do @(posedge clk_i);
    while (req_queue.size() != 0 || pix_in.valid || owed_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all three registers back to back, only while the block is idle
  task automatic write_regs(logic [FW_W-1:0] w, logic [FH_W-1:0] h, logic [KS_W-1:0] k);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx[0] = CFG_FRAME_WIDTH;  val[0] = CFG_DATA_W'(w);
    idx[1] = CFG_FRAME_HEIGHT; val[1] = CFG_DATA_W'(h);
    idx[2] = CFG_KERNEL_SIZE;  val[2] = CFG_DATA_W'(k);
    for (int i = 0; i < 3; i++) begin
      cfg_we       <= 1'b1;
      cfg_idx      <= idx[i];
      cfg_data     <= val[i];
      cfg_activity <= 1'b1;
      @(posedge clk_i);
    end
    cfg_we       <= 1'b0;
    cfg_activity <= 1'b0;
    // a write restarts the frame in the predictor too
    reg_width  = w;
    reg_height = h;
    reg_kernel = k;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endtask

  // one frame with random content and noise flushes, cut short or with a drain at the end
  task automatic push_frame(int unsigned w, int unsigned h, int unsigned sh, bit cut_short);
    int unsigned total, drain, stop_at;
    total = w * h;
    drain = sh * w + sh;
    if (drain > total) drain = total;
    stop_at = cut_short ? $urandom_range(1, total) : total;
    for (int unsigned p = 0; p < stop_at; p++) begin
      // early flush, ignored by the block
      if ($urandom_range(0, 9) == 0) push_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 7) == 0)
        push_req(1'b0, $urandom_range(0, 1) ? 8'hff : 8'h00,
                 $urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00);
      else
        push_random_pixel();
    end
    if (cut_short) return;
    // pixels past the frame end behave as flushes
    for (int unsigned d = 0; d < drain; d++) begin
      if ($urandom_range(0, 4) == 0) push_random_pixel();
      else push_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(0, 2)) push_req(1'b1, 8'h00, 8'h00, 8'h00);
  endtask

  initial begin
    int unsigned w, h, sh, frames;
    logic [FW_W-1:0] rw;
    logic [FH_W-1:0] rh;
    logic [KS_W-1:0] rk;

    mismatches   = 0;
    req_count    = 0;
    rsp_count    = 0;
    frame_count  = 0;
    pushed       = 0;
    phases       = 0;
    idle_cycles  = 0;
    burst_mode   = 1'b0;
    cfg_activity = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_FRAME_WIDTH;
    cfg_data     = '0;
    for (int i = 0; i < MAX_K * MAX_W; i++) ring_mem[i] = '0;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    reg_width  = FRAME_WIDTH_RST;
    reg_height = FRAME_HEIGHT_RST;
    reg_kernel = KERNEL_SIZE_RST;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: 3x3 frame, kernel 3, extreme samples, one interior pixel
    write_regs(11'd3, 13'd3, 3'd3);
    push_req(1'b1, 8'hff, 8'hff, 8'hff);           // flush before the frame is complete
    push_req(1'b0, 8'h00, 8'hff, 8'h00);
    push_req(1'b0, 8'hff, 8'h00, 8'hff);
    push_req(1'b0, 8'h00, 8'h00, 8'h00);
    push_req(1'b0, 8'hff, 8'hff, 8'hff);
    push_req(1'b0, 8'h80, 8'h7f, 8'h01);
    push_req(1'b0, 8'h00, 8'h00, 8'h00);
    push_req(1'b0, 8'hff, 8'hff, 8'hff);
    push_req(1'b0, 8'h55, 8'haa, 8'hfe);
    push_req(1'b0, 8'h00, 8'hff, 8'h00);
    push_req(1'b0, 8'h12, 8'h34, 8'h56);           // pixel past the frame end drains
    push_req(1'b1, 8'h00, 8'h00, 8'h00);
    push_req(1'b1, 8'h00, 8'h00, 8'h00);
    push_req(1'b1, 8'h00, 8'h00, 8'h00);
    push_req(1'b1, 8'h00, 8'h00, 8'h00);           // nothing pending any more
    wait_idle();

    // directed: zero width and height, kernel zero -> single pixel frames
    write_regs(11'd0, 13'd0, 3'd0);
    push_req(1'b0, 8'hff, 8'h00, 8'h7f);
    push_req(1'b0, 8'h01, 8'hfe, 8'h80);
    wait_idle();

    // directed: oversized registers saturate, largest kernel, frame cut short
    write_regs(11'd2047, 13'd8191, 3'd7);
    repeat (4) push_random_pixel();
    wait_idle();

    // directed: even kernel, rounded down to odd, on a 2x2 frame
    write_regs(11'd2, 13'd2, 3'd2);
    repeat (4) push_random_pixel();
    push_req(1'b1, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // random phases: mostly complete frames of small size
    while (pushed < 1000 + 25) begin
      rw = ($urandom_range(0, 3) == 0) ? FW_W'($urandom_range(0, 16)) :
                                         FW_W'($urandom_range(3, 8));
      rh = ($urandom_range(0, 3) == 0) ? FH_W'($urandom_range(0, 12)) :
                                         FH_W'($urandom_range(3, 7));
      rk = KS_W'($urandom_range(0, 7));
      write_regs(rw, rh, rk);
      w = eff_width(rw);
      h = eff_height(rh);
      sh = eff_half(rk);
      burst_mode = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(1, 2);
      for (int f = 0; f < frames; f++)
        push_frame(w, h, sh, (f == frames - 1) && ($urandom_range(0, 9) == 0));
      wait_idle();
      phases++;
    end

    if (owed_pixels.size() != 0) mismatches += owed_pixels.size();
    $display("%0d requests and %0d results checked over %0d frames", req_count, rsp_count,
             frame_count);
    $display("%0d random register settings beyond the directed ones", phases);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mf2d_pkg.sv
rtl/mf2d_in_if.sv
rtl/mf2d_out_if.sv
rtl/mf2d_ram.sv
rtl/median_filter_2d.sv
rtl/mf2d_checker.sv
tb/median_filter_2d_tb.sv
